>>> rtl/w2sbp_pkg.sv
`default_nettype none
package w2sbp_pkg;

  // input item kinds
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_BOX   = 2'd1;
  localparam logic [1:0] MODE_POINT = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_SCREEN_W = 3'd0;
  localparam logic [2:0] REG_SCREEN_H = 3'd1;
  localparam logic [2:0] REG_NEAR     = 3'd2;
  localparam logic [2:0] REG_HEAD     = 3'd3;
  localparam logic [2:0] REG_FOOT     = 3'd4;

  // quotient bits kept by the divider, offset limit is 2^OFF_LOG
  localparam int OFF_LOG = 20;
  localparam int Q_BITS  = OFF_LOG + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CLIP = 5'b00010,
    S_PREP = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

endpackage
`default_nettype wire

>>> rtl/world_to_screen_box_projection_core.sv
`default_nettype none
// world-to-screen box projection core
// in_*  : stream of items. tuser = mode (0 load matrix entry, 1 box, 2 point).
//         a load writes one matrix entry; mode 3 is dropped.
// out_* : one result per projection item, visible flag on tuser.
// cfg_* : register writes (index, data), always ready; write only while idle.
// flow: a projection item runs through one shared 33x33 multiplier and one
//   restoring divider stage. clip coordinates come from 11 products through
//   the product register. each division job has a setup of two partial
//   products of half-size times magnitude, then 1 range check and up to 21
//   quotient steps. point mode runs 2 jobs, box mode 4 jobs; a culled item
//   ends after clip. in_tready is high only while the sequencer is idle.
// stall: the result sits in the output register until taken; the next item
//   may be accepted meanwhile, and its result waits in the last step until
//   the output register is free.
// reset: matrix cleared to zero, registers back to 1920, 1080, 6554, 25, 35,
//   no result pending.
module world_to_screen_box_projection_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // matrix_index[3:0], matrix_value[35:4], world_x[67:36], world_y[99:68],
  // world_z[131:100], zero fill
  input  wire  [135:0] in_tdata,
  // mode[1:0]
  input  wire  [1:0]   in_tuser,
  output logic         out_tvalid,
  input  wire          out_tready,
  // screen_x[15:0], screen_y[31:16], box_height[47:32], box_width[63:48]
  output logic [63:0]  out_tdata,
  // visible[0]
  output logic         out_tuser,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [2:0]   cfg_addr,
  input  wire  [31:0]  cfg_data
);
  import w2sbp_pkg::*;

  // clip value width, product width, remainder width
  localparam int CW = 68 - FRAC_BITS;
  localparam int PW = CW + 13;
  localparam int RW = CW + 22;
  localparam logic [4:0] CHECK_STEP = 5'(Q_BITS);
  localparam logic [Q_BITS-1:0] OFF_MAX = Q_BITS'(1) << OFF_LOG;

  state_t state_r;

  logic [13:0] screen_w_r, screen_h_r;
  logic [30:0] near_r;
  logic [9:0]  head_r, foot_r;
  logic signed [31:0] mat_r [16];

  logic signed [31:0] x_r, y_r, z_r;
  logic               box_r;
  logic               culled_r;
  logic [3:0]         cnt_r;
  logic signed [CW-1:0] cx_r, cy_r, w_r, ctop_r, cbot_r;
  logic signed [65:0] prod_r;

  logic [1:0]         job_r;
  logic [1:0]         pcnt_r;
  logic               neg_r;
  logic [CW-1:0]      a_r;
  logic [CW-1:0]      d_r;
  logic [12:0]        k_r;
  logic [RW-1:0]      rem_r;
  logic [Q_BITS-1:0]  q_r;
  logic [4:0]         bi_r;
  logic signed [21:0] off_r [4];

  logic               out_valid_r;
  logic [63:0]        out_data_r;
  logic               out_vis_r;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_vis_r;

  wire in_acc = in_tvalid && in_tready;
  wire [1:0] in_mode = in_tuser;

  logic [12:0] hw, hh;
  assign hw = screen_w_r[13:1];
  assign hh = screen_h_r[13:1];

  // shared multiplier operands
  logic signed [32:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_CLIP) begin
      unique case (cnt_r)
        4'd0:  begin mul_a = 33'(x_r); mul_b = 33'(mat_r[0]);  end
        4'd1:  begin mul_a = 33'(y_r); mul_b = 33'(mat_r[4]);  end
        4'd2:  begin mul_a = 33'(z_r); mul_b = 33'(mat_r[8]);  end
        4'd3:  begin mul_a = 33'(x_r); mul_b = 33'(mat_r[1]);  end
        4'd4:  begin mul_a = 33'(y_r); mul_b = 33'(mat_r[5]);  end
        4'd5:  begin mul_a = 33'(z_r); mul_b = 33'(mat_r[9]);  end
        4'd6:  begin mul_a = 33'(x_r); mul_b = 33'(mat_r[3]);  end
        4'd7:  begin mul_a = 33'(y_r); mul_b = 33'(mat_r[7]);  end
        4'd8:  begin mul_a = 33'(z_r); mul_b = 33'(mat_r[11]); end
        4'd9:  begin mul_a = {23'd0, head_r}; mul_b = 33'(mat_r[9]); end
        4'd10: begin mul_a = {23'd0, foot_r}; mul_b = 33'(mat_r[9]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_r == S_PREP) begin
      mul_a = {20'd0, k_r};
      if (pcnt_r == 2'd1) mul_b = {1'b0, a_r[31:0]};
      else mul_b = {{(65-CW){1'b0}}, a_r[CW-1:32]};
    end
  end

  // floored term of the clip sums
  logic signed [CW-1:0] term;
  assign term = CW'(prod_r >>> FRAC_BITS);

  // division job operands
  logic signed [CW-1:0] job_num;
  always_comb begin
    unique case (job_r)
      2'd0: job_num = cx_r;
      2'd1: job_num = box_r ? ctop_r : cy_r;
      2'd2: job_num = cbot_r;
      2'd3: job_num = ctop_r + cbot_r;
      default: job_num = cx_r;
    endcase
  end
  wire job_last = box_r ? (job_r == 2'd3) : (job_r == 2'd1);

  logic [RW-1:0] trial;
  assign trial = RW'(d_r) << bi_r;
  wire rem_ge = (rem_r >= trial);

  // offset of the finishing job
  logic [Q_BITS-1:0]  mag;
  logic signed [21:0] off_new;
  always_comb begin
    if (bi_r == CHECK_STEP) mag = OFF_MAX;
    else begin
      mag = q_r | (rem_ge && (bi_r == 5'd0) ? Q_BITS'(1) : '0);
      if (mag > OFF_MAX) mag = OFF_MAX;
    end
    off_new = neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end
  wire sat_hit = (bi_r == CHECK_STEP) && rem_ge;
  wire div_done = sat_hit || (bi_r == 5'd0);

  function automatic logic [15:0] sat16(input logic signed [23:0] v);
    if (v > 24'sd32767) return 16'h7fff;
    else if (v < -24'sd32768) return 16'h8000;
    else return v[15:0];
  endfunction

  // final result from the stored offsets
  logic signed [23:0] sx, sy, ht, wd;
  always_comb begin
    sx = $signed({11'd0, hw}) + 24'(off_r[0]);
    if (box_r) begin
      sy = $signed({11'd0, hh}) - 24'(off_r[3]);
      ht = 24'(off_r[1]) - 24'(off_r[2]);
    end else begin
      sy = $signed({11'd0, hh}) - 24'(off_r[1]);
      ht = '0;
    end
    wd = (ht + $signed(24'(ht[23]))) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      screen_w_r  <= 14'd1920;
      screen_h_r  <= 14'd1080;
      near_r      <= 31'd6554;
      head_r      <= 10'd25;
      foot_r      <= 10'd35;
      for (int i = 0; i < 16; i++) mat_r[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_addr)
          REG_SCREEN_W: screen_w_r <= cfg_data[13:0];
          REG_SCREEN_H: screen_h_r <= cfg_data[13:0];
          REG_NEAR:     near_r     <= cfg_data[30:0];
          REG_HEAD:     head_r     <= cfg_data[9:0];
          REG_FOOT:     foot_r     <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready && state_r != S_OUT) out_valid_r <= 1'b0;
      prod_r <= mul_a * mul_b;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_mode == MODE_LOAD) begin
              mat_r[in_tdata[3:0]] <= in_tdata[35:4];
            end else if (in_mode == MODE_BOX || in_mode == MODE_POINT) begin
              x_r   <= in_tdata[67:36];
              y_r   <= in_tdata[99:68];
              z_r   <= in_tdata[131:100];
              box_r <= (in_mode == MODE_BOX);
              cx_r  <= CW'(mat_r[12]);
              cy_r  <= CW'(mat_r[13]);
              w_r   <= CW'(mat_r[15]);
              cnt_r <= '0;
              state_r <= S_CLIP;
            end
          end
        end
        S_CLIP: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r >= 4'd1 && cnt_r <= 4'd3) cx_r <= cx_r + term;
          else if (cnt_r >= 4'd4 && cnt_r <= 4'd6) cy_r <= cy_r + term;
          else if (cnt_r >= 4'd7 && cnt_r <= 4'd9) w_r <= w_r + term;
          else if (cnt_r == 4'd10) ctop_r <= cy_r + CW'(prod_r);
          else if (cnt_r == 4'd11) begin
            cbot_r <= cy_r - CW'(prod_r);
            if (w_r < $signed(CW'(near_r)) || w_r == '0) begin
              culled_r <= 1'b1;
              state_r  <= S_OUT;
            end else begin
              culled_r <= 1'b0;
              job_r    <= '0;
              pcnt_r   <= '0;
              state_r  <= S_PREP;
            end
          end
        end
        S_PREP: begin
          pcnt_r <= pcnt_r + 2'd1;
          unique case (pcnt_r)
            2'd0: begin
              neg_r <= job_num[CW-1];
              a_r   <= job_num[CW-1] ? CW'(-job_num) : CW'(job_num);
              k_r   <= (job_r == 2'd0) ? hw : hh;
              d_r   <= (job_r == 2'd3) ? CW'({w_r, 1'b0}) : CW'(w_r);
            end
            2'd1: ;
            2'd2: rem_r <= RW'(prod_r[PW-1:0]);
            2'd3: begin
              rem_r   <= rem_r + RW'({prod_r[PW-33:0], 32'd0});
              q_r     <= '0;
              bi_r    <= CHECK_STEP;
              state_r <= S_DIV;
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (bi_r != CHECK_STEP && rem_ge) begin
            rem_r <= rem_r - trial;
            q_r   <= q_r | (Q_BITS'(1) << bi_r);
          end
          if (div_done) begin
            off_r[job_r] <= off_new;
            if (job_last) state_r <= S_OUT;
            else begin
              job_r   <= job_r + 2'd1;
              pcnt_r  <= '0;
              state_r <= S_PREP;
            end
          end else begin
            bi_r <= (bi_r == CHECK_STEP) ? CHECK_STEP - 5'd1 : bi_r - 5'd1;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_vis_r   <= !culled_r;
            if (culled_r) out_data_r <= '0;
            else out_data_r <= {sat16(wd), sat16(ht), sat16(sy), sat16(sx)};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a culled result carries all-zero pixel fields
  a_cull_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 64'd0))
    else $error("culled result with nonzero fields");

  // a projection item blocks the input on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == MODE_BOX || in_tuser == MODE_POINT))
      |=> !in_tready)
    else $error("input ready while projecting");

  // divider quotient holds no bits at or below the current step
  a_quot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && bi_r != CHECK_STEP)
      |-> ((q_r & ((Q_BITS'(1) << (bi_r + 5'd1)) - Q_BITS'(1))) == '0))
    else $error("quotient bits at or below current step");

  // a point in point mode never reports a box
  a_point_box: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !box_r && (!out_valid_r || out_tready))
      |=> (out_tdata[63:32] == 32'd0))
    else $error("box fields set in point mode");

endmodule
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import w2sbp_pkg::*;

  localparam int FRAC = 16;
  localparam longint OFF_MAX = 64'sd1 << OFF_LOG;

  // one result item as the block reports it
  typedef struct packed {
    logic        vis;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] bh;
    logic [15:0] bw;
  } proj_t;

  // one row of the directed table
  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  idx;
    logic [31:0] val;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        typed;
    proj_t       res;
  } row_t;

  localparam proj_t CULLED = '0;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  wire          in_tready;
  logic [135:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  wire          out_tvalid;
  logic         out_tready = 1'b0;
  wire  [63:0]  out_tdata;
  wire          out_tuser;
  logic         cfg_valid = 1'b0;
  wire          cfg_ready;
  logic [2:0]   cfg_addr = '0;
  logic [31:0]  cfg_data = '0;

  // typed expectation travels with the item it belongs to
  logic         item_typed = 1'b0;
  proj_t        item_res = '0;

  world_to_screen_box_projection_core #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's state
  logic [31:0] mat [16];
  logic [13:0] scr_w, scr_h;
  logic [30:0] near_w;
  logic [9:0]  head_off, foot_off;

  proj_t  pending_q[$];
  int     errors = 0;
  int     n_loads = 0, n_vis = 0, n_culled = 0, n_skipped = 0;
  bit     hold_req = 1'b0;

  // trunc(k*num/d), magnitude capped at the offset limit
  function automatic longint scaled_off(longint num, longint k, longint d);
    logic [127:0] mag, prod, quo;
    bit neg;
    neg  = num < 0;
    mag  = neg ? 128'(-num) : 128'(num);
    prod = mag * 128'(k);
    quo  = prod / 128'(d);
    if (quo > 128'(OFF_MAX)) quo = 128'(OFF_MAX);
    return neg ? -longint'(quo) : longint'(quo);
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic longint ent(int r, int c);
    return longint'(signed'(mat[r*4+c]));
  endfunction

  function automatic longint clip_of(longint x, longint y, longint z, int c);
    return ((x * ent(0, c)) >>> FRAC) + ((y * ent(1, c)) >>> FRAC)
         + ((z * ent(2, c)) >>> FRAC) + ent(3, c);
  endfunction

  // expected result of one projection item
  function automatic proj_t project(logic [1:0] mode, logic [31:0] wx, logic [31:0] wy,
                                    logic [31:0] wz);
    proj_t  r;
    longint x, y, z, cx, cy, cw, hw, hh, ctop, cbot, top, bot, hgt;
    r  = '0;
    x  = longint'(signed'(wx));
    y  = longint'(signed'(wy));
    z  = longint'(signed'(wz));
    cx = clip_of(x, y, z, 0);
    cy = clip_of(x, y, z, 1);
    cw = clip_of(x, y, z, 3);
    if (cw < longint'(near_w) || cw == 0) return r;
    hw = longint'(scr_w / 2);
    hh = longint'(scr_h / 2);
    r.vis = 1'b1;
    r.sx  = clamp16(hw + scaled_off(cx, hw, cw));
    if (mode == MODE_POINT) begin
      r.sy = clamp16(hh - scaled_off(cy, hh, cw));
    end else begin
      ctop = cy + longint'(head_off) * ent(2, 1);
      cbot = cy - longint'(foot_off) * ent(2, 1);
      top  = hh - scaled_off(ctop, hh, cw);
      bot  = hh - scaled_off(cbot, hh, cw);
      hgt  = bot - top;
      r.sy = clamp16(hh - scaled_off(ctop + cbot, hh, 2 * cw));
      r.bh = clamp16(hgt);
      r.bw = clamp16(hgt / 2);
    end
    return r;
  endfunction

  // input and config monitor: update the shadow state, queue expectations
  always @(posedge clk) begin
    proj_t p;
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_SCREEN_W: scr_w    = cfg_data[13:0];
        REG_SCREEN_H: scr_h    = cfg_data[13:0];
        REG_NEAR:     near_w   = cfg_data[30:0];
        REG_HEAD:     head_off = cfg_data[9:0];
        REG_FOOT:     foot_off = cfg_data[9:0];
        default: ;
      endcase
    end
    if (rst_n && in_tvalid && in_tready) begin
      if (in_tuser == MODE_LOAD) begin
        mat[in_tdata[3:0]] = in_tdata[35:4];
        n_loads++;
      end else if (in_tuser == MODE_BOX || in_tuser == MODE_POINT) begin
        p = project(in_tuser, in_tdata[67:36], in_tdata[99:68], in_tdata[131:100]);
        if (item_typed) p = item_res;
        pending_q = {pending_q, p};
        if (p.vis) n_vis++;
        else n_culled++;
      end else begin
        n_skipped++;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    proj_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[15:0], out_tdata[31:16], out_tdata[47:32],
             out_tdata[63:48]};
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got.vis !== want.vis) begin
          $display("%0t: visible exp %b got %b", $time, want.vis, got.vis);
          errors++;
        end
        if (got.sx !== want.sx) begin
          $display("%0t: screen_x exp %0d got %0d", $time, signed'(want.sx), signed'(got.sx));
          errors++;
        end
        if (got.sy !== want.sy) begin
          $display("%0t: screen_y exp %0d got %0d", $time, signed'(want.sy), signed'(got.sy));
          errors++;
        end
        if (got.bh !== want.bh) begin
          $display("%0t: box_height exp %0d got %0d", $time, signed'(want.bh),
                   signed'(got.bh));
          errors++;
        end
        if (got.bw !== want.bw) begin
          $display("%0t: box_width exp %0d got %0d", $time, signed'(want.bw),
                   signed'(got.bw));
          errors++;
        end
      end
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    int g;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        // stretch with no stalls
        out_tready <= 1'b1;
        repeat ($urandom_range(50, 200)) @(posedge clk);
      end else begin
        g = pick_gap();
        if (g > 0) begin
          out_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  bit burst = 1'b0;

  task automatic send_item(logic [1:0] mode, logic [3:0] idx, logic [31:0] val,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic typed, proj_t res);
    int g;
    g = burst ? 0 : pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tuser   <= mode;
    in_tdata   <= {4'd0, z, y, x, val, idx};
    item_typed <= typed;
    item_res   <= res;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every result is back and the sequencer has settled
  task automatic drain();
    in_tvalid <= 1'b0;
    item_typed <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_world();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(0, 2000)) - 1000) <<< FRAC;
      default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  // matrix entries: w column biased positive so many points survive culling
  function automatic logic [31:0] rand_entry(logic [3:0] idx);
    if ($urandom_range(0, 9) == 0) return $urandom();
    if (idx == 4'd15) return $urandom_range(0, 1 << 26);
    if (idx[1:0] == 2'd3) return 32'($signed($urandom_range(0, 1 << 14)) - (1 << 13));
    return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
  endfunction

  row_t dir_tab[22];

  initial begin
    logic [1:0] m;
    logic [3:0] ix;
    int        r;
    dir_tab = '{
      // fresh matrix is all zero so clip w is zero: culled
      '{MODE_BOX,   4'd0,  32'h0, 32'h0, 32'h0, 32'h0, 1'b1, CULLED},
      '{MODE_POINT, 4'd0,  32'h0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1, CULLED},
      // unused mode is dropped
      '{2'd3,       4'd15, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
        1'b0, CULLED},
      '{MODE_LOAD,  4'd0,  32'h00010000, 32'h0, 32'h0, 32'h0, 1'b0, CULLED},
      '{MODE_LOAD,  4'd5,  32'h00010000, 32'h0, 32'h0, 32'h0, 1'b0, CULLED},
      '{MODE_LOAD,  4'd9,  32'h00010000, 32'h0, 32'h0, 32'h0, 1'b0, CULLED},
      '{MODE_LOAD,  4'd15, 32'h00010000, 32'h0, 32'h0, 32'h0, 1'b0, CULLED},
      '{MODE_POINT, 4'd0,  32'h0, 32'h0, 32'h0, 32'h0, 1'b1,
        '{1'b1, 16'd960, 16'd540, 16'd0, 16'd0}},
      '{MODE_BOX,   4'd0,  32'h0, 32'h0, 32'h0, 32'h0, 1'b0, CULLED},
      '{MODE_POINT, 4'd0,  32'h0, 32'h7fffffff, 32'h80000000, 32'h0, 1'b0, CULLED},
      '{MODE_BOX,   4'd0,  32'h0, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0, CULLED},
      // w column offset entry at its most negative: culled
      '{MODE_LOAD,  4'd15, 32'h80000000, 32'h0, 32'h0, 32'h0, 1'b0, CULLED},
      '{MODE_BOX,   4'd0,  32'h0, 32'h0, 32'h0, 32'h0, 1'b1, CULLED},
      '{MODE_LOAD,  4'd15, 32'h7fffffff, 32'h0, 32'h0, 32'h0, 1'b0, CULLED},
      '{MODE_LOAD,  4'd3,  32'h80000000, 32'h0, 32'h0, 32'h0, 1'b0, CULLED},
      '{MODE_LOAD,  4'd7,  32'h7fffffff, 32'h0, 32'h0, 32'h0, 1'b0, CULLED},
      '{MODE_LOAD,  4'd11, 32'hffffffff, 32'h0, 32'h0, 32'h0, 1'b0, CULLED},
      '{MODE_POINT, 4'd0,  32'h0, 32'h00001000, 32'h7fffffff, 32'h80000000, 1'b0, CULLED},
      '{MODE_BOX,   4'd0,  32'h0, 32'hffffffff, 32'h0, 32'h7fffffff, 1'b0, CULLED},
      '{MODE_LOAD,  4'd9,  32'h7fffffff, 32'h0, 32'h0, 32'h0, 1'b0, CULLED},
      '{MODE_BOX,   4'd0,  32'h0, 32'h00100000, 32'h00200000, 32'h00010000, 1'b0, CULLED},
      '{MODE_BOX,   4'd0,  32'h0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, CULLED}
    };
    for (int i = 0; i < 16; i++) mat[i] = '0;
    scr_w = 14'd1920; scr_h = 14'd1080; near_w = 31'd6554;
    head_off = 10'd25; foot_off = 10'd35;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset settings
    foreach (dir_tab[i])
      send_item(dir_tab[i].mode, dir_tab[i].idx, dir_tab[i].val, dir_tab[i].x,
                dir_tab[i].y, dir_tab[i].z, dir_tab[i].typed, dir_tab[i].res);

    // random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin
          // zero half size on both axes, no near limit
          write_reg(REG_SCREEN_W, 32'd1);
          write_reg(REG_SCREEN_H, 32'd1);
          write_reg(REG_NEAR, 32'd0);
          write_reg(REG_HEAD, 32'd0);
          write_reg(REG_FOOT, 32'd0);
        end
        1: begin
          write_reg(REG_SCREEN_W, 32'd8192);
          write_reg(REG_SCREEN_H, 32'd8192);
          write_reg(REG_NEAR, 32'd1);
          write_reg(REG_HEAD, 32'd1023);
          write_reg(REG_FOOT, 32'd1023);
        end
        2: begin
          // nearly everything culled, upper bits of the data bus set
          write_reg(REG_NEAR, 32'hffffffff);
          write_reg(REG_SCREEN_W, 32'hffffc000 | 32'd1920);
          write_reg(3'd5, $urandom());
          write_reg(3'd7, $urandom());
        end
        default: begin
          write_reg(REG_SCREEN_W, $urandom_range(1, 8192));
          write_reg(REG_SCREEN_H, $urandom_range(1, 8192));
          write_reg(REG_NEAR, $urandom_range(0, 1 << 18));
          write_reg(REG_HEAD, $urandom_range(0, 1023));
          write_reg(REG_FOOT, $urandom_range(0, 1023));
          write_reg(3'd6, $urandom());
        end
      endcase
      if (ph == 3) hold_req = 1'b1;
      for (int n = 0; n < 90; n++) begin
        burst = (ph == 3) || ($urandom_range(0, 5) == 0);
        r = $urandom_range(0, 19);
        if (r < 5) begin
          ix = $urandom_range(0, 15);
          send_item(MODE_LOAD, ix, rand_entry(ix), $urandom(), $urandom(), $urandom(),
                    1'b0, CULLED);
        end else if (r == 5) begin
          send_item(2'd3, 4'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
                    1'b0, CULLED);
        end else begin
          m = (r < 13) ? MODE_BOX : MODE_POINT;
          send_item(m, 4'($urandom()), $urandom(), rand_world(), rand_world(), rand_world(),
                    1'b0, CULLED);
        end
      end
      burst = 1'b0;
    end

    drain();
    if (pending_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_q.size());
      errors++;
    end
    $display("covered %0d matrix loads, %0d visible and %0d culled points, %0d dropped items",
             n_loads, n_vis, n_culled, n_skipped);
    $display("over six register settings with a long output stall, %0d mismatches", errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("%0t: timeout", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> world_to_screen_box_projection_core.f
rtl/w2sbp_pkg.sv
rtl/world_to_screen_box_projection_core.sv
sim/testbench.sv
